### hdl/seafu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse edge attractive force package
// Shared field widths, command codes, transaction types and state encodings.
// ----------------------------------------------------------------------------
package seafu_pkg;

   localparam int POINT_W  = 10;
   localparam int DIM_W    = 2;
   localparam int COORD_W  = 32;
   localparam int WEIGHT_W = 32;
   localparam int FORCE_W  = 48;
   localparam int CFG_W    = 3;

   localparam logic [CFG_W-1:0] DIMS_RESET = 3'd2;

   localparam logic [1:0] CMD_COORD_WR = 2'd0;
   localparam logic [1:0] CMD_FORCE_WR = 2'd1;
   localparam logic [1:0] CMD_EDGE     = 2'd2;
   localparam logic [1:0] CMD_FORCE_RD = 2'd3;

   typedef struct packed {
      logic [1:0]                cmd;
      logic [POINT_W-1:0]        point;
      logic [POINT_W-1:0]        other_point;
      logic [DIM_W-1:0]          dim;
      logic signed [COORD_W-1:0] coordinate;
      logic [WEIGHT_W-1:0]       weight;
      logic signed [FORCE_W-1:0] force_value;
   } req_type;

   typedef struct packed {
      logic signed [FORCE_W-1:0] force_out;
      logic [POINT_W-1:0]        point_echo;
      logic [DIM_W-1:0]          dim_echo;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_COORD,
      OP_FORCE,
      OP_EDGE,
      OP_READ,
      OP_READ_ZERO
   } op_type;

   typedef struct packed {
      op_type  op;
      req_type req;
   } q_entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CWR,
      ST_FWR,
      ST_RD,
      ST_RSP,
      ST_DIF_RD,
      ST_DIF_SUB,
      ST_DIF_SQ,
      ST_DIF_ACC,
      ST_DIV,
      ST_UPD_RD,
      ST_UPD_WR
   } back_state_type;

endpackage
`default_nettype wire

### hdl/seafu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse edge attractive force front end
// Classifies incoming commands, drops out-of-range writes and edges, and
// holds classified transactions in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module seafu_front #(
   parameter int NUM_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  take,
   input  wire seafu_pkg::req_type    req,
   output      logic                  full,
   output      logic                  head_valid,
   output      seafu_pkg::q_entry_type head,
   input  wire logic                  pop
);

   logic                   p_ok;
   logic                   o_ok;
   logic                   d_ok;
   logic                   keep;
   seafu_pkg::op_type      op;
   seafu_pkg::q_entry_type slot_ff [2];
   logic                   wptr_ff;
   logic                   rptr_ff;
   logic [1:0]             count_ff;
   logic [1:0]             count_in;
   logic                   push;

   assign p_ok = 32'(req.point) < 32'(NUM_POINTS);
   assign o_ok = 32'(req.other_point) < 32'(NUM_POINTS);
   assign d_ok = 32'(req.dim) < 32'(MAX_DIMS);

   always_comb begin
      keep = 1'b0;
      op   = seafu_pkg::OP_COORD;
      unique case (req.cmd)
         seafu_pkg::CMD_COORD_WR: begin
            keep = p_ok && d_ok;
            op   = seafu_pkg::OP_COORD;
         end
         seafu_pkg::CMD_FORCE_WR: begin
            keep = p_ok && d_ok;
            op   = seafu_pkg::OP_FORCE;
         end
         seafu_pkg::CMD_EDGE: begin
            keep = p_ok && o_ok;
            op   = seafu_pkg::OP_EDGE;
         end
         seafu_pkg::CMD_FORCE_RD: begin
            // a read always answers; out-of-range reads answer zero
            keep = 1'b1;
            op   = (p_ok && d_ok) ? seafu_pkg::OP_READ : seafu_pkg::OP_READ_ZERO;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push       = take && keep;
   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head       = slot_ff[rptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= ~wptr_ff;
         end
         if (pop) begin
            rptr_ff <= ~rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= '{op: op, req: req};
      end
   end

endmodule
`default_nettype wire

### hdl/seafu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse edge attractive force back end
// Owns the coordinate and force memories, clears the force memory after
// reset, and executes queued transactions: writes, reads and edge updates
// with a one-bit-per-cycle divider.
// ----------------------------------------------------------------------------
module seafu_back #(
   parameter int NUM_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [seafu_pkg::CFG_W-1:0] dims,
   input  wire logic                        head_valid,
   input  wire seafu_pkg::q_entry_type      head,
   output      logic                        pop,
   output      logic                        clearing,
   output      logic                        rsp_valid,
   output      seafu_pkg::rsp_type          rsp_data
);

   localparam int ENTRIES = NUM_POINTS * MAX_DIMS;
   localparam int ADDR_W  = $clog2(ENTRIES);
   localparam int CW      = $clog2(MAX_DIMS + 1);
   localparam int KW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int FW      = seafu_pkg::FORCE_W;

   logic signed [seafu_pkg::COORD_W-1:0] coord_mem [ENTRIES];
   logic signed [FW-1:0]                 force_mem [ENTRIES];

   seafu_pkg::back_state_type state_ff;
   seafu_pkg::back_state_type state_in;
   seafu_pkg::q_entry_type    cur_ff;

   logic [ADDR_W-1:0] clr_ff;
   logic [CW-1:0]     k_ff;
   logic [KW-1:0]     k_idx;
   logic [CW-1:0]     eff_dims;
   logic              last_k;
   logic              last_clr;
   logic [4:0]        bit_ff;

   logic signed [seafu_pkg::COORD_W-1:0] cra_ff;
   logic signed [seafu_pkg::COORD_W-1:0] crb_ff;
   logic signed [FW-1:0]                 frd_ff;
   logic [31:0]                          mag_ff [MAX_DIMS];
   logic                                 neg_ff [MAX_DIMS];
   logic [63:0]                          sq_ff;
   logic [63:0]                          sum_ff;
   logic [63:0]                          rem_ff;
   logic [31:0]                          quo_ff;
   logic [63:0]                          prod_ff;

   logic [ADDR_W-1:0] c_raddr_a;
   logic [ADDR_W-1:0] c_raddr_b;
   logic              c_we;
   logic [ADDR_W-1:0] c_waddr;
   logic [ADDR_W-1:0] f_raddr;
   logic              f_we;
   logic [ADDR_W-1:0] f_waddr;
   logic [FW-1:0]     f_wdata;

   logic signed [32:0] diff;
   logic [32:0]        diff_abs;
   logic [64:0]        sum_wide;
   logic [64:0]        rem_sh;
   logic [64:0]        trial;
   logic               qbit;
   logic signed [49:0] cterm;
   logic signed [49:0] fsum;
   logic [FW-1:0]      fsat;

   function automatic logic [ADDR_W-1:0] entry_addr(
      input logic [seafu_pkg::POINT_W-1:0] pt,
      input logic [ADDR_W-1:0]             ofs
   );
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(pt) * ADDR_W'(MAX_DIMS);
      return base + ofs;
   endfunction

   assign k_idx    = k_ff[KW-1:0];
   assign eff_dims = (32'(dims) > 32'(MAX_DIMS)) ? CW'(MAX_DIMS) : CW'(dims);
   assign last_k   = k_ff == (eff_dims - CW'(1));
   assign last_clr = clr_ff == ADDR_W'(ENTRIES - 1);
   assign clearing = state_ff == seafu_pkg::ST_CLEAR;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         seafu_pkg::ST_CLEAR: begin
            if (last_clr) begin
               state_in = seafu_pkg::ST_IDLE;
            end
         end
         seafu_pkg::ST_IDLE: begin
            if (head_valid) begin
               unique case (head.op)
                  seafu_pkg::OP_COORD:     state_in = seafu_pkg::ST_CWR;
                  seafu_pkg::OP_FORCE:     state_in = seafu_pkg::ST_FWR;
                  seafu_pkg::OP_READ:      state_in = seafu_pkg::ST_RD;
                  seafu_pkg::OP_READ_ZERO: state_in = seafu_pkg::ST_RSP;
                  seafu_pkg::OP_EDGE: begin
                     // zero dimensions: the edge changes nothing
                     state_in = (eff_dims == '0) ? seafu_pkg::ST_IDLE : seafu_pkg::ST_DIF_RD;
                  end
                  default: state_in = seafu_pkg::ST_IDLE;
               endcase
            end
         end
         seafu_pkg::ST_CWR:     state_in = seafu_pkg::ST_IDLE;
         seafu_pkg::ST_FWR:     state_in = seafu_pkg::ST_IDLE;
         seafu_pkg::ST_RD:      state_in = seafu_pkg::ST_RSP;
         seafu_pkg::ST_RSP:     state_in = seafu_pkg::ST_IDLE;
         seafu_pkg::ST_DIF_RD:  state_in = seafu_pkg::ST_DIF_SUB;
         seafu_pkg::ST_DIF_SUB: state_in = seafu_pkg::ST_DIF_SQ;
         seafu_pkg::ST_DIF_SQ:  state_in = seafu_pkg::ST_DIF_ACC;
         seafu_pkg::ST_DIF_ACC: begin
            state_in = last_k ? seafu_pkg::ST_DIV : seafu_pkg::ST_DIF_RD;
         end
         seafu_pkg::ST_DIV: begin
            if (bit_ff == 5'd31) begin
               state_in = seafu_pkg::ST_UPD_RD;
            end
         end
         seafu_pkg::ST_UPD_RD:  state_in = seafu_pkg::ST_UPD_WR;
         seafu_pkg::ST_UPD_WR: begin
            state_in = last_k ? seafu_pkg::ST_IDLE : seafu_pkg::ST_UPD_RD;
         end
         default: state_in = seafu_pkg::ST_IDLE;
      endcase
   end

   // datapath arithmetic
   always_comb begin
      diff     = 33'(cra_ff) - 33'(crb_ff);
      diff_abs = diff[32] ? -diff : diff;
      sum_wide = {1'b0, sum_ff} + {1'b0, sq_ff};
      rem_sh   = {rem_ff, 1'b0};
      trial    = rem_sh - {1'b0, sum_ff};
      qbit     = rem_sh >= {1'b0, sum_ff};
      cterm    = $signed({2'b00, prod_ff[63:16]});
      if (neg_ff[k_idx]) begin
         cterm = -cterm;
      end
      fsum = 50'(frd_ff) + cterm;
      if (fsum > 50'sd140737488355327) begin
         fsat = {1'b0, {(FW-1){1'b1}}};
      end else if (fsum < -50'sd140737488355328) begin
         fsat = {1'b1, {(FW-1){1'b0}}};
      end else begin
         fsat = fsum[FW-1:0];
      end
   end

   // outputs and memory controls
   always_comb begin
      pop       = 1'b0;
      rsp_valid = 1'b0;
      c_we      = 1'b0;
      c_waddr   = entry_addr(cur_ff.req.point, ADDR_W'(cur_ff.req.dim));
      c_raddr_a = entry_addr(cur_ff.req.point, ADDR_W'(k_idx));
      c_raddr_b = entry_addr(cur_ff.req.other_point, ADDR_W'(k_idx));
      f_raddr   = entry_addr(cur_ff.req.point, ADDR_W'(k_idx));
      f_we      = 1'b0;
      f_waddr   = entry_addr(cur_ff.req.point, ADDR_W'(k_idx));
      f_wdata   = fsat;
      unique case (state_ff)
         seafu_pkg::ST_CLEAR: begin
            f_we    = 1'b1;
            f_waddr = clr_ff;
            f_wdata = '0;
         end
         seafu_pkg::ST_IDLE: begin
            pop = head_valid;
         end
         seafu_pkg::ST_CWR: begin
            c_we = 1'b1;
         end
         seafu_pkg::ST_FWR: begin
            f_we    = 1'b1;
            f_waddr = c_waddr;
            f_wdata = cur_ff.req.force_value;
         end
         seafu_pkg::ST_RD: begin
            f_raddr = c_waddr;
         end
         seafu_pkg::ST_RSP: begin
            rsp_valid = 1'b1;
         end
         seafu_pkg::ST_UPD_WR: begin
            f_we = 1'b1;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_data.force_out  = (cur_ff.op == seafu_pkg::OP_READ) ? frd_ff : '0;
      rsp_data.point_echo = cur_ff.req.point;
      rsp_data.dim_echo   = cur_ff.req.dim;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= seafu_pkg::ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == seafu_pkg::ST_CLEAR) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         seafu_pkg::ST_IDLE: begin
            cur_ff <= head;
            k_ff   <= '0;
            sum_ff <= 64'h1_0000_0000;
         end
         seafu_pkg::ST_DIF_SUB: begin
            mag_ff[k_idx] <= diff_abs[31:0];
            neg_ff[k_idx] <= diff[32];
         end
         seafu_pkg::ST_DIF_SQ: begin
            sq_ff <= 64'(mag_ff[k_idx]) * 64'(mag_ff[k_idx]);
         end
         seafu_pkg::ST_DIF_ACC: begin
            // saturate the distance sum at all ones
            sum_ff <= sum_wide[64] ? '1 : sum_wide[63:0];
            rem_ff <= 64'(cur_ff.req.weight);
            bit_ff <= '0;
            k_ff   <= last_k ? '0 : k_ff + CW'(1);
         end
         seafu_pkg::ST_DIV: begin
            rem_ff <= qbit ? trial[63:0] : rem_sh[63:0];
            quo_ff <= {quo_ff[30:0], qbit};
            bit_ff <= bit_ff + 5'd1;
         end
         seafu_pkg::ST_UPD_RD: begin
            prod_ff <= 64'(quo_ff) * 64'(mag_ff[k_idx]);
         end
         seafu_pkg::ST_UPD_WR: begin
            k_ff <= k_ff + CW'(1);
         end
         default: begin
            bit_ff <= bit_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         coord_mem[c_waddr] <= cur_ff.req.coordinate;
      end
      cra_ff <= coord_mem[c_raddr_a];
      crb_ff <= coord_mem[c_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         force_mem[f_waddr] <= f_wdata;
      end
      frd_ff <= force_mem[f_raddr];
   end

endmodule
`default_nettype wire

### hdl/sparse_edge_attractive_force_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse edge attractive force unit
// Holds Q16.16 point coordinates and Q16.32 saturating force accumulators;
// commands write a coordinate, preset a force entry, add one weighted edge's
// attractive force, or read a force entry back.
// ----------------------------------------------------------------------------
// Usage: after reset the force memory is cleared one entry per cycle, all
// NUM_POINTS*MAX_DIMS entries, with busy high. A command is taken when start is
// high and busy is low; a two-entry queue sits in front of the execution unit.
// Results are a one-cycle rsp_valid strobe that cannot be stalled. Steps per
// command: a write is one write state; a force read reads, then answers (zero
// and unread if point or dim is out of range); an edge reads, subtracts,
// squares and sums each dimension, divides the weight bit-serially by one
// plus the squared distance, then updates each force (skipped for zero dims).
// ----------------------------------------------------------------------------
module sparse_edge_attractive_force_unit #(
   parameter int NUM_POINTS = 1024,
   parameter int MAX_DIMS   = 4
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output      logic                        busy,
   input  wire seafu_pkg::req_type          req_data,
   output      logic                        rsp_valid,
   output      seafu_pkg::rsp_type          rsp_data,
   input  wire logic                        csr_valid,
   output      logic                        csr_ready,
   input  wire logic [seafu_pkg::CFG_W-1:0] csr_data
);

   logic [seafu_pkg::CFG_W-1:0] dims_ff;
   logic                        q_full;
   logic                        head_valid;
   seafu_pkg::q_entry_type      head;
   logic                        pop;
   logic                        clearing;

   assign csr_ready = 1'b1;
   assign busy      = q_full || clearing;

   always_ff @(posedge clock) begin
      if (reset) begin
         dims_ff <= seafu_pkg::DIMS_RESET;
      end else if (csr_valid && csr_ready) begin
         dims_ff <= csr_data;
      end
   end

   seafu_front #(
      .NUM_POINTS (NUM_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (start && !busy),
      .req        (req_data),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop)
   );

   seafu_back #(
      .NUM_POINTS (NUM_POINTS),
      .MAX_DIMS   (MAX_DIMS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .dims       (dims_ff),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

### verif/sparse_edge_attractive_force_unit_test.sv
// ----------------------------------------------------------------------------
// Sparse edge attractive force unit testbench
// Feeds coordinate writes, force presets, weighted edges and force reads
// through the command port under several dimension settings and sender
// idle rates. A local model of the coordinate and force memories predicts
// every force read, and the monitor compares each response field by field.
// ----------------------------------------------------------------------------
module sparse_edge_attractive_force_unit_test;
   import seafu_pkg::*;

   localparam int NPTS      = 1024;
   localparam int NDIMS     = 4;
   localparam int NENT      = NPTS * NDIMS;
   localparam int DRAIN     = 300;
   localparam int MAX_CYC   = 2000000;
   localparam int POOL_N    = 12;
   localparam longint F_MAX = (64'sd1 <<< 47) - 1;
   localparam longint F_MIN = -(64'sd1 <<< 47);

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   req_type          req_data = '0;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   sparse_edge_attractive_force_unit dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // model state
   logic signed [COORD_W-1:0] coord_mem [NENT];
   logic signed [FORCE_W-1:0] force_mem [NENT];
   logic [CFG_W-1:0]          dims_reg = DIMS_RESET;

   req_type     pending_q [$];
   rsp_type     expected_reads [$];
   int          sender_idle_pct = 16;
   int          error_count = 0;
   int          items_accepted = 0;
   int          reads_checked = 0;
   int          edges_accepted = 0;
   int          cycle_count = 0;

   // stimulus-side bookkeeping
   bit          coord_set [NENT];
   int          pool [POOL_N];
   logic [CFG_W-1:0] stim_dims = DIMS_RESET;

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0h want %0h (read %0d)", what, got, want, reads_checked);
      error_count++;
   endtask

   function automatic void add_edge_force(input int p, input int o, input logic [31:0] w);
      int          nd;
      longint      diff [NDIMS];
      logic [63:0] s, mag, q, prod;
      logic [64:0] sum;
      longint      c, acc;
      nd = (dims_reg > NDIMS) ? NDIMS : int'(dims_reg);
      s = 64'h1_0000_0000;
      for (int k = 0; k < nd; k++) begin
         diff[k] = longint'(coord_mem[p*NDIMS+k]) - longint'(coord_mem[o*NDIMS+k]);
         mag = (diff[k] < 0) ? 64'(-diff[k]) : 64'(diff[k]);
         sum = {1'b0, s} + {1'b0, mag * mag};
         s = sum[64] ? '1 : sum[63:0];
      end
      q = {w, 32'h0} / s;
      for (int k = 0; k < nd; k++) begin
         mag = (diff[k] < 0) ? 64'(-diff[k]) : 64'(diff[k]);
         prod = q * mag;
         c = longint'(prod >> 16);
         if (diff[k] < 0) c = -c;
         acc = longint'(force_mem[p*NDIMS+k]) + c;
         if (acc > F_MAX) acc = F_MAX;
         if (acc < F_MIN) acc = F_MIN;
         force_mem[p*NDIMS+k] = acc[FORCE_W-1:0];
      end
   endfunction

   // advance the model by one accepted transaction
   function automatic void model_accept(input req_type r);
      int      idx;
      rsp_type rsp;
      idx = int'(r.point) * NDIMS + int'(r.dim);
      case (r.cmd)
         CMD_COORD_WR: coord_mem[idx] = r.coordinate;
         CMD_FORCE_WR: force_mem[idx] = r.force_value;
         CMD_EDGE: begin
            add_edge_force(int'(r.point), int'(r.other_point), r.weight);
            edges_accepted++;
         end
         default: begin
            rsp.force_out  = force_mem[idx];
            rsp.point_echo = r.point;
            rsp.dim_echo   = r.dim;
            expected_reads.insert(expected_reads.size(), rsp);
         end
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      logic take;
      if (reset) begin
         start <= 1'b0;
      end else begin
         take = 1'b0;
         if (start && !busy) begin
            model_accept(req_data);
            items_accepted++;
            take = 1'b1;
         end
         if (!start || take) begin
            if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pending_q.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_reads.size() == 0) begin
            report_mismatch("unexpected response", longint'(rsp_data), 0);
         end else begin
            want = expected_reads.pop_front();
            if (rsp_data.force_out !== want.force_out)
               report_mismatch("force_out", longint'(rsp_data.force_out),
                               longint'(want.force_out));
            if (rsp_data.point_echo !== want.point_echo)
               report_mismatch("point_echo", longint'(rsp_data.point_echo),
                               longint'(want.point_echo));
            if (rsp_data.dim_echo !== want.dim_echo)
               report_mismatch("dim_echo", longint'(rsp_data.dim_echo),
                               longint'(want.dim_echo));
            reads_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= MAX_CYC) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_type make_req(input logic [1:0] cmd, input int p, input int o,
                                        input int d, input logic [31:0] crd,
                                        input logic [31:0] w, input logic [47:0] f);
      req_type r;
      r.cmd = cmd;
      r.point = p[POINT_W-1:0];
      r.other_point = o[POINT_W-1:0];
      r.dim = d[DIM_W-1:0];
      r.coordinate = crd;
      r.weight = w;
      r.force_value = f;
      return r;
   endfunction

   task automatic queue_item(input req_type r);
      if (r.cmd == CMD_COORD_WR) coord_set[int'(r.point)*NDIMS + int'(r.dim)] = 1'b1;
      pending_q.insert(pending_q.size(), r);
   endtask

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom();
         1:       return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(1048576)) - 524288);
      endcase
   endfunction

   function automatic logic [47:0] rand_force();
      case ($urandom_range(3))
         0:       return {16'($urandom()), 32'($urandom())};
         1:       return $urandom_range(1) ? 48'h7FFF_FFFF_FFFF : 48'h8000_0000_0000;
         default: return 48'($signed({$urandom_range(1) ? 16'hFFFF : 16'h0, 32'($urandom())}));
      endcase
   endfunction

   // edges stay inside the point pool; any coordinate the edge needs that was
   // never written is written first instead
   task automatic queue_random_item();
      int          p, o, d, nd, pick;
      logic [31:0] w;
      req_type     r;
      pick = $urandom_range(99);
      d = $urandom_range(3);
      w = ($urandom_range(4) == 0) ? ($urandom_range(1) ? 32'hFFFF_FFFF : 32'h0) : $urandom();
      if (pick < 45) begin
         p = pool[$urandom_range(POOL_N-1)];
         o = ($urandom_range(9) == 0) ? p : pool[$urandom_range(POOL_N-1)];
         nd = (stim_dims > NDIMS) ? NDIMS : int'(stim_dims);
         for (int k = 0; k < nd; k++) begin
            if (!coord_set[p*NDIMS+k]) begin
               queue_item(make_req(CMD_COORD_WR, p, $urandom(), k, rand_coord(), $urandom(),
                                   rand_force()));
               return;
            end
            if (!coord_set[o*NDIMS+k]) begin
               queue_item(make_req(CMD_COORD_WR, o, $urandom(), k, rand_coord(), $urandom(),
                                   rand_force()));
               return;
            end
         end
         r = make_req(CMD_EDGE, p, o, d, $urandom(), w, rand_force());
      end else begin
         p = ($urandom_range(2) == 0) ? $urandom_range(NPTS-1) : pool[$urandom_range(POOL_N-1)];
         if (pick < 60)
            r = make_req(CMD_COORD_WR, p, $urandom(), d, rand_coord(), w, rand_force());
         else if (pick < 70)
            r = make_req(CMD_FORCE_WR, p, $urandom(), d, $urandom(), w, rand_force());
         else
            r = make_req(CMD_FORCE_RD, p, $urandom(), d, $urandom(), w, rand_force());
      end
      queue_item(r);
   endtask

   task automatic wait_drained();
      while (pending_q.size() > 0 || start) @(posedge clock);
      while (expected_reads.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_dims(input logic [CFG_W-1:0] value);
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      dims_reg  = value;
      stim_dims = value;
   endtask

   initial begin
      logic [CFG_W-1:0] phase_dims [7];
      int               phase_idle [7];
      phase_dims = '{DIMS_RESET, 3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5};
      phase_idle = '{16, 16, 16, 48, 48, 0, 0};
      for (int i = 0; i < NENT; i++) begin
         coord_mem[i] = '0;
         force_mem[i] = '0;
         coord_set[i] = 1'b0;
      end
      pool[0] = 0;
      pool[1] = NPTS - 1;
      for (int i = 2; i < POOL_N; i++) pool[i] = $urandom_range(NPTS-1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: extreme coordinates, saturation in both directions, self edge
      queue_item(make_req(CMD_COORD_WR, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
      queue_item(make_req(CMD_COORD_WR, 0, 0, 1, 32'h8000_0000, 0, 0));
      queue_item(make_req(CMD_COORD_WR, NPTS-1, 0, 0, 32'h8000_0000, 0, 0));
      queue_item(make_req(CMD_COORD_WR, NPTS-1, 0, 1, 32'h7FFF_FFFF, 0, 0));
      queue_item(make_req(CMD_EDGE, 0, NPTS-1, 0, 0, 32'hFFFF_FFFF, 0));
      queue_item(make_req(CMD_EDGE, NPTS-1, NPTS-1, 3, 0, 32'hFFFF_FFFF, 0));
      queue_item(make_req(CMD_FORCE_RD, 0, 0, 0, 0, 0, 0));
      queue_item(make_req(CMD_FORCE_RD, 0, 0, 1, 0, 0, 0));
      queue_item(make_req(CMD_FORCE_RD, NPTS-1, 0, 0, 0, 0, 0));
      queue_item(make_req(CMD_COORD_WR, 5, 0, 0, 32'h0001_0000, 0, 0));
      queue_item(make_req(CMD_COORD_WR, 5, 0, 1, 32'h0, 0, 0));
      queue_item(make_req(CMD_COORD_WR, 6, 0, 0, 32'h0, 0, 0));
      queue_item(make_req(CMD_COORD_WR, 6, 0, 1, 32'h0, 0, 0));
      queue_item(make_req(CMD_FORCE_WR, 5, 0, 0, 0, 0, 48'h7FFF_FFFF_FFFE));
      queue_item(make_req(CMD_FORCE_WR, 6, 0, 0, 0, 0, 48'h8000_0000_0001));
      queue_item(make_req(CMD_EDGE, 5, 6, 0, 0, 32'hFFFF_FFFF, 0));
      queue_item(make_req(CMD_EDGE, 6, 5, 0, 0, 32'hFFFF_FFFF, 0));
      queue_item(make_req(CMD_EDGE, 5, 6, 2, 0, 32'h0, 0));
      queue_item(make_req(CMD_FORCE_RD, 5, 0, 0, 0, 0, 0));
      queue_item(make_req(CMD_FORCE_RD, 6, 0, 0, 0, 0, 0));
      queue_item(make_req(CMD_FORCE_RD, 7, 0, 3, 0, 0, 0));

      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) begin
            wait_drained();
            write_dims(phase_dims[ph]);
         end
         sender_idle_pct = phase_idle[ph];
         for (int n = 0; n < 172; n++) queue_random_item();
      end
      wait_drained();

      $display("Ran %0d transactions (%0d edges) over 7 dimension settings, 0 through 7,",
               items_accepted, edges_accepted);
      $display("with %0d force reads checked and %0d mismatches.", reads_checked, error_count);
      if (error_count == 0 && expected_reads.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
hdl/seafu_pkg.sv
hdl/seafu_front.sv
hdl/seafu_back.sv
hdl/sparse_edge_attractive_force_unit.sv
verif/sparse_edge_attractive_force_unit_test.sv
